### src/ihg_pkg.sv
package ihg_pkg;

    localparam int NUM_WORDS  = 6;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int LANE_W     = HALF_W + 1;
    localparam int SUM_W      = 20;
    localparam int OFF_W      = SUM_W + 1;
    localparam int PROD_W     = OFF_W + WORD_W;
    localparam int SHIFT      = 16;
    localparam int MAG_W      = 36;
    localparam int TOTAL_W    = MAG_W + 2;
    localparam int SAMPLE_W   = 16;
    localparam int NUM_STAGES = 5;

    localparam logic [HALF_W-1:0]   HALF_MASK = 16'hFFFF;
    localparam logic [OFF_W-1:0]    CENTRE    = OFF_W'(NUM_WORDS * 32'(HALF_MASK));
    localparam logic [PROD_W-1:0]   ROUND     = PROD_W'(32'h8000);
    localparam logic signed [TOTAL_W-1:0] SAT_MAX = TOTAL_W'(32767);
    localparam logic signed [TOTAL_W-1:0] SAT_MIN = -TOTAL_W'(32768);

    typedef struct packed {
        logic mul;
        logic rnd;
        logic fin;
    } scale_en_t;

endpackage

### src/ihg_if.sv
interface ihg_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] rand_word_0;
    logic        [31:0] rand_word_1;
    logic        [31:0] rand_word_2;
    logic        [31:0] rand_word_3;
    logic        [31:0] rand_word_4;
    logic        [31:0] rand_word_5;
    logic signed [31:0] mean_value;
    logic signed [31:0] std_dev;

    modport source (
        output valid, rand_word_0, rand_word_1, rand_word_2, rand_word_3,
               rand_word_4, rand_word_5, mean_value, std_dev,
        input  ready
    );
    modport sink (
        input  valid, rand_word_0, rand_word_1, rand_word_2, rand_word_3,
               rand_word_4, rand_word_5, mean_value, std_dev,
        output ready
    );
endinterface

interface ihg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (
        output valid, sample,
        input  ready
    );
    modport sink (
        input  valid, sample,
        output ready
    );
endinterface

### src/ihg_lane.sv
module ihg_lane (
    input  logic                              clk,
    input  logic                              en,
    input  logic [ihg_pkg::WORD_W-1:0]        word,
    output logic [ihg_pkg::LANE_W-1:0]        half_sum
);

    logic [ihg_pkg::LANE_W-1:0] half_sum_reg;
    logic [ihg_pkg::LANE_W-1:0] half_sum_next;

    assign half_sum_next = ihg_pkg::LANE_W'(word[ihg_pkg::WORD_W-1:ihg_pkg::HALF_W])
                         + ihg_pkg::LANE_W'(word[ihg_pkg::HALF_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            half_sum_reg <= half_sum_next;
        end
    end

    assign half_sum = half_sum_reg;

endmodule

### src/ihg_merge.sv
module ihg_merge (
    input  logic                                                clk,
    input  logic                                                en,
    input  logic [ihg_pkg::NUM_WORDS-1:0][ihg_pkg::LANE_W-1:0]  half_sum,
    output logic signed [ihg_pkg::OFF_W-1:0]                    offset
);

    logic [ihg_pkg::SUM_W-1:0]        pair_a;
    logic [ihg_pkg::SUM_W-1:0]        pair_b;
    logic [ihg_pkg::SUM_W-1:0]        pair_c;
    logic [ihg_pkg::SUM_W-1:0]        total;
    logic signed [ihg_pkg::OFF_W-1:0] offset_reg;
    logic signed [ihg_pkg::OFF_W-1:0] offset_next;

    assign pair_a = ihg_pkg::SUM_W'(half_sum[0]) + ihg_pkg::SUM_W'(half_sum[1]);
    assign pair_b = ihg_pkg::SUM_W'(half_sum[2]) + ihg_pkg::SUM_W'(half_sum[3]);
    assign pair_c = ihg_pkg::SUM_W'(half_sum[4]) + ihg_pkg::SUM_W'(half_sum[5]);
    assign total  = pair_a + pair_b + pair_c;

    assign offset_next = $signed(ihg_pkg::OFF_W'(total) - ihg_pkg::CENTRE);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            offset_reg <= offset_next;
        end
    end

    assign offset = offset_reg;

endmodule

### src/ihg_scale.sv
module ihg_scale (
    input  logic                                clk,
    input  ihg_pkg::scale_en_t                  en,
    input  logic signed [ihg_pkg::OFF_W-1:0]    offset,
    input  logic signed [ihg_pkg::WORD_W-1:0]   dev,
    input  logic                                dev_pos,
    input  logic signed [ihg_pkg::WORD_W-1:0]   mean,
    output logic signed [ihg_pkg::SAMPLE_W-1:0] sample
);

    logic signed [ihg_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ihg_pkg::PROD_W-1:0]   prod_next;
    logic        [ihg_pkg::PROD_W-1:0]   prod_abs;
    logic        [ihg_pkg::PROD_W-1:0]   prod_rnd;
    logic        [ihg_pkg::MAG_W-1:0]    mag_reg;
    logic                                neg_reg;
    logic signed [ihg_pkg::WORD_W-1:0]   mean_mul_reg;
    logic signed [ihg_pkg::WORD_W-1:0]   mean_rnd_reg;
    logic                                pos_mul_reg;
    logic                                pos_rnd_reg;
    logic signed [ihg_pkg::TOTAL_W-1:0]  scaled;
    logic signed [ihg_pkg::TOTAL_W-1:0]  total;
    logic signed [ihg_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [ihg_pkg::SAMPLE_W-1:0] sample_next;

    assign prod_next = ihg_pkg::PROD_W'(offset) * ihg_pkg::PROD_W'(dev);

    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg     <= prod_next;
            mean_mul_reg <= mean;
            pos_mul_reg  <= dev_pos;
        end
    end

    // magnitude, round half up, drop the fraction
    assign prod_abs = prod_reg[ihg_pkg::PROD_W-1] ? ihg_pkg::PROD_W'(-prod_reg)
                                                  : ihg_pkg::PROD_W'(prod_reg);
    assign prod_rnd = prod_abs + ihg_pkg::ROUND;

    always_ff @(posedge clk)
    begin
        if (en.rnd)
        begin
            mag_reg      <= prod_rnd[ihg_pkg::SHIFT +: ihg_pkg::MAG_W];
            neg_reg      <= prod_reg[ihg_pkg::PROD_W-1];
            mean_rnd_reg <= mean_mul_reg;
            pos_rnd_reg  <= pos_mul_reg;
        end
    end

    always_comb
    begin
        scaled = $signed({2'b00, mag_reg});
        if (neg_reg)
        begin
            scaled = -scaled;
        end
        total = ihg_pkg::TOTAL_W'(mean_rnd_reg);
        if (pos_rnd_reg)
        begin
            total = total + scaled;
        end
        if (total > ihg_pkg::SAT_MAX)
        begin
            sample_next = ihg_pkg::SAMPLE_W'(ihg_pkg::SAT_MAX);
        end
        else if (total < ihg_pkg::SAT_MIN)
        begin
            sample_next = ihg_pkg::SAMPLE_W'(ihg_pkg::SAT_MIN);
        end
        else
        begin
            sample_next = ihg_pkg::SAMPLE_W'(total);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.fin)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

### src/irwin_hall_gaussian_sample.sv
// A word runs through the lane, merge, multiply, round and saturate stages.
// Throughput: one word per cycle; six lanes sum the word halves in parallel,
// a 21 x 32 multiplier scales the offset, then round and saturate stages.
// Back-pressure stalls the five-stage pipeline, bubbles are squeezed out.
// Reset (rst_n, asynchronous, active low) empties every stage; data is kept.
module irwin_hall_gaussian_sample (
    input logic     clk,
    input logic     rst_n,
    ihg_in_if.sink  item,
    ihg_out_if.source result
);

    logic [ihg_pkg::NUM_STAGES-1:0] vld_reg;
    logic [ihg_pkg::NUM_STAGES-1:0] vld_next;
    logic [ihg_pkg::NUM_STAGES-1:0] en;

    logic [ihg_pkg::NUM_WORDS-1:0][ihg_pkg::WORD_W-1:0] words;
    logic [ihg_pkg::NUM_WORDS-1:0][ihg_pkg::LANE_W-1:0] half_sum;

    logic signed [ihg_pkg::WORD_W-1:0] mean_s1_reg;
    logic signed [ihg_pkg::WORD_W-1:0] mean_s2_reg;
    logic signed [ihg_pkg::WORD_W-1:0] dev_s1_reg;
    logic signed [ihg_pkg::WORD_W-1:0] dev_s2_reg;
    logic                              pos_s1_reg;
    logic                              pos_s2_reg;
    logic signed [ihg_pkg::OFF_W-1:0]  offset;
    ihg_pkg::scale_en_t                scale_en;

    assign words[0] = item.rand_word_0;
    assign words[1] = item.rand_word_1;
    assign words[2] = item.rand_word_2;
    assign words[3] = item.rand_word_3;
    assign words[4] = item.rand_word_4;
    assign words[5] = item.rand_word_5;

    always_comb
    begin
        en[ihg_pkg::NUM_STAGES-1] = !vld_reg[ihg_pkg::NUM_STAGES-1] || result.ready;
        for (int k = ihg_pkg::NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = item.valid;
        end
        for (int k = 1; k < ihg_pkg::NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign item.ready   = en[0];
    assign result.valid = vld_reg[ihg_pkg::NUM_STAGES-1];

    for (genvar i = 0; i < ihg_pkg::NUM_WORDS; i++)
    begin : g_lane
        ihg_lane u_lane (
            .clk      (clk),
            .en       (en[0]),
            .word     (words[i]),
            .half_sum (half_sum[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mean_s1_reg <= item.mean_value;
            dev_s1_reg  <= item.std_dev;
            pos_s1_reg  <= !item.std_dev[ihg_pkg::WORD_W-1] && (|item.std_dev);
        end
        if (en[1])
        begin
            mean_s2_reg <= mean_s1_reg;
            dev_s2_reg  <= dev_s1_reg;
            pos_s2_reg  <= pos_s1_reg;
        end
    end

    ihg_merge u_merge (
        .clk      (clk),
        .en       (en[1]),
        .half_sum (half_sum),
        .offset   (offset)
    );

    assign scale_en.mul = en[2];
    assign scale_en.rnd = en[3];
    assign scale_en.fin = en[4];

    ihg_scale u_scale (
        .clk     (clk),
        .en      (scale_en),
        .offset  (offset),
        .dev     (dev_s2_reg),
        .dev_pos (pos_s2_reg),
        .mean    (mean_s2_reg),
        .sample  (result.sample)
    );

`ifndef SYNTHESIS
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> vld_reg[0])
        else $error("accepted word did not enter the first stage");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !result.ready |-> !item.ready)
        else $error("full pipeline took a new word");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(vld_reg[ihg_pkg::NUM_STAGES-1]) |-> $past(result.ready))
        else $error("sample dropped without being taken");
`endif

endmodule

### dv/irwin_hall_gaussian_sample_tb.sv
`timescale 1ns / 100ps

module irwin_hall_gaussian_sample_tb;

    typedef struct packed {
        logic        [5:0][31:0] words;
        logic signed [31:0]      mean_value;
        logic signed [31:0]      std_dev;
    } draw_t;

    localparam longint HALF_SUM_CENTRE = longint'(ihg_pkg::NUM_WORDS) * 65535;
    localparam int     NUM_PHASES      = 4;
    localparam int     WORDS_PER_PHASE = 385;

    class sample_scoreboard;
        logic signed [15:0] pending_samples[$];
        int                 errors;
        int                 checked;
        int                 accepted;

        function logic signed [15:0] predict_sample(draw_t d);
            longint half_sum;
            longint offset;
            longint mag;
            longint total;
            half_sum = 0;
            if (d.std_dev <= 0)
            begin
                total = longint'(d.mean_value);
            end
            else
            begin
                for (int i = 0; i < ihg_pkg::NUM_WORDS; i++)
                begin
                    half_sum += longint'(d.words[i][31:16]) + longint'(d.words[i][15:0]);
                end
                offset = longint'(d.std_dev) * (half_sum - HALF_SUM_CENTRE);
                mag    = (offset < 0) ? -offset : offset;
                mag    = (mag + 32768) >> 16;
                total  = longint'(d.mean_value) + ((offset < 0) ? -mag : mag);
            end
            if (total > 32767)
                total = 32767;
            if (total < -32768)
                total = -32768;
            return 16'(total);
        endfunction

        function void note_draw(draw_t d);
            pending_samples.push_back(predict_sample(d));
            accepted++;
        endfunction

        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected sample %0d, none expected", $time, got);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            checked++;
            if (got !== want)
            begin
                $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_gap_pct;
    int   stall_pct;

    ihg_in_if  item_ch();
    ihg_out_if sample_ch();

    sample_scoreboard board;
    draw_t            seen;

    irwin_hall_gaussian_sample u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (sample_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("irwin_hall_gaussian_sample regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        sample_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
                board.check_sample(sample_ch.sample);
            if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
            begin
                seen.words[0]   = item_ch.rand_word_0;
                seen.words[1]   = item_ch.rand_word_1;
                seen.words[2]   = item_ch.rand_word_2;
                seen.words[3]   = item_ch.rand_word_3;
                seen.words[4]   = item_ch.rand_word_4;
                seen.words[5]   = item_ch.rand_word_5;
                seen.mean_value = item_ch.mean_value;
                seen.std_dev    = item_ch.std_dev;
                board.note_draw(seen);
            end
        end
    end

    function automatic draw_t uniform_draw(logic [31:0] w, int mean, int dev);
        draw_t d;
        for (int i = 0; i < 6; i++)
            d.words[i] = w;
        d.mean_value = mean;
        d.std_dev    = dev;
        return d;
    endfunction

    // Halves sum to the centre plus delta; delta kept within about +/-32000.
    function automatic draw_t near_centre(int delta, int mean, int dev);
        draw_t d;
        int    lead;
        d    = uniform_draw(32'h7FFF_7FFF, mean, dev);
        lead = 32767 + 6 + delta;
        d.words[0][15:0] = 16'(lead);
        return d;
    endfunction

    function automatic draw_t random_draw();
        draw_t d;
        int    pick;
        for (int i = 0; i < 6; i++)
            d.words[i] = $urandom;
        pick = $urandom_range(99);
        if (pick < 55)
            d.mean_value = int'($urandom_range(40000)) - 20000;
        else if (pick < 80)
            d.mean_value = $urandom;
        else if (pick < 90)
            d.mean_value = 32768 + int'($urandom_range(8)) - 4;
        else
            d.mean_value = -32768 + int'($urandom_range(8)) - 4;
        pick = $urandom_range(99);
        if (pick < 45)
            d.std_dev = $urandom_range(3000, 1);
        else if (pick < 60)
            d.std_dev = $urandom_range(65536, 1);
        else if (pick < 75)
            d.std_dev = $urandom;
        else if (pick < 85)
            d.std_dev = -int'($urandom_range(3));
        else if (pick < 93)
            d = near_centre(int'($urandom_range(4000)) - 2000, d.mean_value & 32'h3FFF,
                            $urandom_range(1 << 20, 1));
        else
            // odd multiple of half an LSB: lands on a rounding tie
            d = near_centre(2 * int'($urandom_range(200)) - 199, int'($urandom_range(2000)) - 1000,
                            32768 * (2 * int'($urandom_range(30)) + 1));
        return d;
    endfunction

    task automatic send_draw(input draw_t d);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.rand_word_0 <= d.words[0];
        item_ch.rand_word_1 <= d.words[1];
        item_ch.rand_word_2 <= d.words[2];
        item_ch.rand_word_3 <= d.words[3];
        item_ch.rand_word_4 <= d.words[4];
        item_ch.rand_word_5 <= d.words[5];
        item_ch.mean_value  <= d.mean_value;
        item_ch.std_dev     <= d.std_dev;
        do
            @(negedge clk);
        while (item_ch.ready !== 1'b1);
        @(posedge clk);
    endtask

    task automatic drain_samples();
        item_ch.valid <= 1'b0;
        while (board.pending_samples.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int gap_pcts[NUM_PHASES];
        int stall_pcts[NUM_PHASES];
        int wait_cycles;

        gap_pcts   = '{0, 64, 0, 18};
        stall_pcts = '{0, 0, 64, 18};
        board = new();
        send_gap_pct = 0;
        stall_pct    = 0;

        rst_n               <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.rand_word_0 <= '0;
        item_ch.rand_word_1 <= '0;
        item_ch.rand_word_2 <= '0;
        item_ch.rand_word_3 <= '0;
        item_ch.rand_word_4 <= '0;
        item_ch.rand_word_5 <= '0;
        item_ch.mean_value  <= '0;
        item_ch.std_dev     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_draw(uniform_draw(32'h0000_0000, 0, 1));
        send_draw(uniform_draw(32'hFFFF_FFFF, 0, 1));
        send_draw(uniform_draw(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF));
        send_draw(uniform_draw(32'h0000_0000, 0, 32'h7FFF_FFFF));
        send_draw(uniform_draw(32'hFFFF_FFFF, 32'h8000_0000, 1));
        send_draw(uniform_draw(32'hFFFF_FFFF, 32767, 1));
        send_draw(uniform_draw($urandom, 32767, 0));
        send_draw(uniform_draw($urandom, 32768, 0));
        send_draw(uniform_draw($urandom, -32768, -1));
        send_draw(uniform_draw($urandom, -32769, -1));
        send_draw(uniform_draw(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_draw(uniform_draw(32'h0000_0000, 32'h8000_0000, 32'h8000_0000));
        send_draw(uniform_draw($urandom, 0, 0));
        send_draw(near_centre(1, 0, 32768));
        send_draw(near_centre(-1, 0, 32768));
        send_draw(near_centre(1, 0, 32767));
        send_draw(near_centre(-1, 0, 32767));
        send_draw(near_centre(3, 100, 32768));
        send_draw(near_centre(-3, -100, 32768));
        send_draw(near_centre(0, -5, 32'h7FFF_FFFF));
        send_draw(uniform_draw(32'hFFFF_0000, 7, 12345));
        send_draw(uniform_draw(32'hAAAA_5555, 1234, 700));
        drain_samples();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_gap_pct = gap_pcts[p];
            stall_pct    = stall_pcts[p];
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_draw(random_draw());
            // hold the sender until the pipeline is empty
            drain_samples();
        end

        stall_pct   = 0;
        wait_cycles = 0;
        while (board.pending_samples.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (board.pending_samples.size() != 0)
        begin
            $display("%0t: %0d samples never arrived", $time, board.pending_samples.size());
            board.errors += board.pending_samples.size();
        end

        $display("%0d words sent across directed cases and %0d idling phases",
                 board.accepted, NUM_PHASES);
        $display("%0d samples compared, %0d errors", board.checked, board.errors);
        if (board.errors == 0)
            $display("irwin_hall_gaussian_sample regression: pass");
        else
            $display("irwin_hall_gaussian_sample regression: fail");
        $finish;
    end

endmodule

### filelist.f
src/ihg_pkg.sv
src/ihg_if.sv
src/ihg_lane.sv
src/ihg_merge.sv
src/ihg_scale.sv
src/irwin_hall_gaussian_sample.sv
dv/irwin_hall_gaussian_sample_tb.sv
